>>> src/pbfs_pkg.sv
package pbfs_pkg;

  // Default store depth in 64-bit words
  localparam int STORE_WORDS_DEF = 64;

  // Word index carried between front and back, wide enough for the largest store
  localparam int WORD_INDEX_BITS = 12;

  // Entries in the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_DROP   = 3'd1;
  localparam logic [2:0] CMD_WRITE  = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Status codes
  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // Input item
  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] bit_position;
    logic [6:0]  field_width;
    logic [63:0] field_value;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [63:0] read_value;
    logic [12:0] length_bits;
    logic        status;
  } res_t;

  // Classified operation handed from front to back
  typedef struct packed {
    logic                       wr_en;
    logic                       rd_en;
    logic                       straddle;
    logic [WORD_INDEX_BITS-1:0] word_index;
    logic [5:0]                 offset;
    logic [63:0]                mask;
    logic [63:0]                bits;
    logic [12:0]                length_bits;
    logic                       status;
  } op_t;

  // Back-end sequencer
  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

endpackage

>>> src/pbfs_queue.sv
module pbfs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pbfs_pkg::op_t  push_op,
  output logic           ready,
  input  logic           pop,
  output logic           valid,
  output pbfs_pkg::op_t  head
);
  import pbfs_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  op_t                 entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign ready = (count != CNT_BITS'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

>>> src/pbfs_front.sv
module pbfs_front #(
  parameter int STORE_WORDS = pbfs_pkg::STORE_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pbfs_pkg::cmd_t in_data,
  output logic           q_push,
  output pbfs_pkg::op_t  q_op,
  input  logic           q_ready
);
  import pbfs_pkg::*;

  localparam int CAP = STORE_WORDS * 64;
  localparam int LW  = $clog2(CAP + 1);
  localparam int AW  = $clog2(STORE_WORDS);
  localparam int CW  = ((LW > 13) ? LW : 13) + 1;

  logic [LW-1:0] len;
  logic [LW-1:0] len_next;

  logic [CW-1:0] len_ext;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] w_ext;
  logic [CW-1:0] field_pos;
  logic          wide;
  logic          rejected;
  logic          mem_wr;
  logic          mem_rd;
  logic [63:0]   mask;
  logic [7:0]    field_end;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  assign len_ext = CW'(len);
  assign pos_ext = CW'(in_data.bit_position);
  assign w_ext   = CW'(in_data.field_width);
  assign wide    = (in_data.field_width > 7'd64);

  // Classify the command: bounds checks, new length, memory action
  always_comb begin
    len_next  = len;
    rejected  = STATUS_DONE;
    mem_wr    = 1'b0;
    mem_rd    = 1'b0;
    field_pos = pos_ext;
    case (in_data.cmd)
      CMD_APPEND: begin
        field_pos = len_ext;
        if (wide || (len_ext + w_ext > CW'(CAP))) begin
          rejected = STATUS_REJECTED;
        end else begin
          len_next = LW'(len_ext + w_ext);
          mem_wr   = (in_data.field_width != '0);
        end
      end
      CMD_DROP: begin
        if (w_ext >= len_ext) begin
          len_next = '0;
        end else begin
          len_next = LW'(len_ext - w_ext);
        end
      end
      CMD_WRITE: begin
        if (wide || (pos_ext + w_ext > len_ext)) begin
          rejected = STATUS_REJECTED;
        end else begin
          mem_wr = (in_data.field_width != '0);
        end
      end
      CMD_READ: begin
        if (wide || (pos_ext + w_ext > len_ext)) begin
          rejected = STATUS_REJECTED;
        end else begin
          mem_rd = (in_data.field_width != '0);
        end
      end
      CMD_CLEAR: begin
        len_next = '0;
      end
      default: begin
        rejected = STATUS_REJECTED;
      end
    endcase
  end

  // Field mask, all ones for a full word
  assign mask = (in_data.field_width >= 7'd64) ? '1
              : ((64'd1 << in_data.field_width[5:0]) - 64'd1);

  // Field runs into the next word
  assign field_end = {2'b00, field_pos[5:0]} + {1'b0, in_data.field_width};

  // Operation for the back end
  always_comb begin
    q_op             = '0;
    q_op.wr_en       = mem_wr;
    q_op.rd_en       = mem_rd;
    q_op.straddle    = (field_end > 8'd64);
    q_op.word_index  = WORD_INDEX_BITS'(field_pos[6 +: AW]);
    q_op.offset      = field_pos[5:0];
    q_op.mask        = mask;
    q_op.bits        = in_data.field_value & mask;
    q_op.length_bits = 13'(CW'(len_next));
    q_op.status      = rejected;
  end

  // Tracked length
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (q_push) begin
      len <= len_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_len_in_capacity: assert property (@(posedge clk) disable iff (rst)
    CW'(len) <= CW'(CAP))
    else $error("length beyond capacity");

  a_reject_keeps_len: assert property (@(posedge clk) disable iff (rst)
    q_push && (rejected == STATUS_REJECTED) |=> len == $past(len))
    else $error("rejected item changed the length");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    q_push && (in_data.cmd == CMD_CLEAR) |=> len == '0)
    else $error("clear left bits in the store");
`endif

endmodule

>>> src/pbfs_back.sv
module pbfs_back #(
  parameter int STORE_WORDS = pbfs_pkg::STORE_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  pbfs_pkg::op_t  head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output pbfs_pkg::res_t out_data
);
  import pbfs_pkg::*;

  localparam int AW   = $clog2(STORE_WORDS);
  localparam int ROWS = (STORE_WORDS + 1) / 2;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Even and odd word banks: a field's two words always sit in different banks
  logic [63:0] bank_even [ROWS];
  logic [63:0] bank_odd  [ROWS];

  bk_state_t   state;
  bk_state_t   state_next;

  logic [63:0] rd_even;
  logic [63:0] rd_odd;

  logic [AW-1:0] lo_idx;
  logic [AW:0]   lo_half;
  logic          lo_odd;
  logic [RW-1:0] even_row;
  logic [RW-1:0] odd_row;

  logic [63:0] lo_word;
  logic [63:0] hi_word;
  logic [63:0] new_lo;
  logic [63:0] new_hi;
  logic [63:0] field_rd;
  logic [6:0]  hi_shift;

  logic        even_we;
  logic        odd_we;
  logic [63:0] even_wdata;
  logic [63:0] odd_wdata;
  logic        finish;

  // Bank addressing from the head of the queue
  assign lo_idx   = head.word_index[AW-1:0];
  assign lo_odd   = lo_idx[0];
  assign lo_half  = (AW+1)'(lo_idx) >> 1;
  assign even_row = RW'(lo_odd ? lo_half + (AW+1)'(1) : lo_half);
  assign odd_row  = RW'(lo_half);

  // Registered bank reads
  always_ff @(posedge clk) begin
    rd_even <= bank_even[even_row];
    rd_odd  <= bank_odd[odd_row];
  end

  // Merge and extract
  assign lo_word  = lo_odd ? rd_odd  : rd_even;
  assign hi_word  = lo_odd ? rd_even : rd_odd;
  assign hi_shift = 7'd64 - {1'b0, head.offset};
  assign new_lo   = (lo_word & ~(head.mask << head.offset)) | (head.bits << head.offset);
  assign new_hi   = (hi_word & ~(head.mask >> hi_shift)) | (head.bits >> hi_shift);
  assign field_rd = ((lo_word >> head.offset)
                  | (head.straddle ? (hi_word << hi_shift) : 64'd0)) & head.mask;

  // Sequencer: read both banks, then write back and post the result
  always_comb begin
    state_next = state;
    finish     = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!out_valid || out_ready) begin
          finish     = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign q_pop = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Bank writes
  assign even_we    = finish && head.wr_en && (!lo_odd || head.straddle);
  assign odd_we     = finish && head.wr_en && (lo_odd || head.straddle);
  assign even_wdata = lo_odd ? new_hi : new_lo;
  assign odd_wdata  = lo_odd ? new_lo : new_hi;

  always_ff @(posedge clk) begin
    if (even_we) begin
      bank_even[even_row] <= even_wdata;
    end
    if (odd_we) begin
      bank_odd[odd_row] <= odd_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.read_value  <= head.rd_en ? field_rd : 64'd0;
      out_data.length_bits <= head.length_bits;
      out_data.status      <= head.status;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && (state == BK_EXEC))
    else $error("queue popped without an item in execution");

  a_stall_holds_exec: assert property (@(posedge clk) disable iff (rst)
    (state == BK_EXEC) && out_valid && !out_ready |=> state == BK_EXEC)
    else $error("item left execution while the result was stalled");

  a_pop_posts_result: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> out_valid)
    else $error("finished item gave no result");

  a_no_write_when_rejected: assert property (@(posedge clk) disable iff (rst)
    (even_we || odd_we) |-> head.status == STATUS_DONE)
    else $error("rejected item wrote the store");
`endif

endmodule

>>> src/packed_bit_field_store.sv
// Packed bit field store: a bit string of tracked length held in 64-bit words.
// Input channel in_valid/in_ready/in_data carries one command per item
// (append, drop tail, write field, read field, clear); output channel
// out_valid/out_ready/out_data returns exactly one result per item, in order:
// the read field (zero for other commands), the length after the command and
// a done/rejected status.
// The result is registered: the item passes the queue, the back end's bank
// read register and the output register. The back end handles one item at a
// time: it reads the two word banks, then writes back once the output is free.
// A two-entry queue sits between the checking front end and the back end, so
// the input keeps taking items while a result waits at the output.
// Reset clears the length to zero, empties the queue and drops any pending
// result; the word banks are not cleared, and only bits inside the length are
// ever returned. When the receiver stalls, the result is held in the output
// register, the back end stops, and the input stalls once the queue is full.
module packed_bit_field_store #(
  parameter int STORE_WORDS = pbfs_pkg::STORE_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pbfs_pkg::cmd_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pbfs_pkg::res_t out_data
);
  import pbfs_pkg::*;

  logic q_push;
  logic q_ready;
  logic q_pop;
  logic q_valid;
  op_t  q_op;
  op_t  q_head;

  pbfs_front #(
    .STORE_WORDS(STORE_WORDS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_op     (q_op),
    .q_ready  (q_ready)
  );

  pbfs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_op),
    .ready   (q_ready),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  pbfs_back #(
    .STORE_WORDS(STORE_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/sv/tb_packed_bit_field_store.sv
module tb_packed_bit_field_store;
  import pbfs_pkg::*;

  localparam int DEPTH_WORDS = STORE_WORDS_DEF;
  localparam int CAPACITY_BITS = DEPTH_WORDS * 64;
  localparam int RANDOM_ITEMS = 1225;
  localparam int HOLD_AFTER = 500;    // results taken before the long hold-off
  localparam int HOLD_CYCLES = 64;
  localparam int DRAIN_CYCLES = 8;

  // Codes the block does not define
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  // One row of the directed table; check_typed selects the typed-in result
  typedef struct packed {
    cmd_t item;
    logic check_typed;
    res_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cmd_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;

  bit no_idle = 1'b0;
  int mismatches = 0;

  // Predicted state of the store
  logic [63:0] model_words [DEPTH_WORDS];
  logic [12:0] model_len = '0;

  res_t predicted_results [$];
  plan_row_t directed_plan [$];

  packed_bit_field_store #(
    .STORE_WORDS(DEPTH_WORDS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Field mask; a full 64-bit field takes every bit
  function automatic logic [63:0] ones_below(int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  // Place a field of 1..64 bits, spilling into the next word if it straddles
  function automatic void store_field(int unsigned pos, int unsigned w, logic [63:0] v);
    logic [63:0] m;
    logic [63:0] b;
    int unsigned off;
    int unsigned lo;
    int unsigned hi;
    m = ones_below(w);
    b = v & m;
    off = pos % 64;
    lo = (pos / 64) % DEPTH_WORDS;
    hi = (lo + 1) % DEPTH_WORDS;
    model_words[lo] = (model_words[lo] & ~(m << off)) | (b << off);
    if (off + w > 64) begin
      model_words[hi] = (model_words[hi] & ~(m >> (64 - off))) | (b >> (64 - off));
    end
  endfunction

  // Advance the predicted store by one command and return its result
  function automatic res_t apply_command(cmd_t c);
    res_t r;
    int unsigned pos;
    int unsigned w;
    int unsigned off;
    int unsigned lo;
    logic [63:0] m;
    r = '0;
    r.status = STATUS_DONE;
    pos = 32'(c.bit_position);
    w = 32'(c.field_width);
    case (c.cmd)
      CMD_APPEND: begin
        if (w > 64 || model_len + w > CAPACITY_BITS) begin
          r.status = STATUS_REJECTED;
        end else if (w != 0) begin
          store_field(32'(model_len), w, c.field_value);
          model_len = 13'(model_len + w);
        end
      end
      CMD_DROP: begin
        if (w >= model_len) model_len = '0;
        else model_len = 13'(model_len - w);
      end
      CMD_WRITE: begin
        if (w > 64 || pos + w > model_len) r.status = STATUS_REJECTED;
        else if (w != 0) store_field(pos, w, c.field_value);
      end
      CMD_READ: begin
        if (w > 64 || pos + w > model_len) begin
          r.status = STATUS_REJECTED;
        end else if (w != 0) begin
          m = ones_below(w);
          off = pos % 64;
          lo = (pos / 64) % DEPTH_WORDS;
          r.read_value = (model_words[lo] >> off) & m;
          if (off + w > 64) begin
            r.read_value |= (model_words[(lo + 1) % DEPTH_WORDS] << (64 - off)) & m;
          end
        end
      end
      CMD_CLEAR: model_len = '0;
      default: r.status = STATUS_REJECTED;
    endcase
    r.length_bits = model_len;
    return r;
  endfunction

  function automatic plan_row_t plan_row(logic [2:0] op, int unsigned pos, int unsigned w,
                                         logic [63:0] v, int typed, int unsigned len,
                                         logic st);
    plan_row_t p;
    p.item.cmd = op;
    p.item.bit_position = 12'(pos);
    p.item.field_width = 7'(w);
    p.item.field_value = v;
    p.check_typed = (typed != 0);
    p.want.read_value = '0;
    p.want.length_bits = 13'(len);
    p.want.status = st;
    return p;
  endfunction

  // Append a row to the directed table
  function automatic void add_row(plan_row_t p);
    directed_plan.insert(directed_plan.size(), p);
  endfunction

  // Random command; grow phases push the string towards full capacity
  function automatic cmd_t draw_command(bit grow);
    cmd_t c;
    int unsigned pick;
    int unsigned w;
    int unsigned len;
    len = 32'(model_len);
    pick = $urandom_range(0, 99);
    c.field_value = {$urandom, $urandom};
    c.bit_position = 12'($urandom_range(0, 4095));
    if ($urandom_range(0, 19) == 0) w = $urandom_range(65, 127);
    else w = $urandom_range(0, 64);
    if (grow) begin
      if (pick < 80) begin
        c.cmd = CMD_APPEND;
        if (w <= 64) w = $urandom_range(32, 64);
      end else begin
        c.cmd = (pick < 90) ? CMD_READ : CMD_WRITE;
      end
    end else begin
      if (pick < 30) c.cmd = CMD_APPEND;
      else if (pick < 42) c.cmd = CMD_DROP;
      else if (pick < 62) c.cmd = CMD_READ;
      else if (pick < 82) c.cmd = CMD_WRITE;
      else if (pick < 86) c.cmd = CMD_CLEAR;
      else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0: c.cmd = CMD_SPARE_LO;
          1: c.cmd = CMD_SPARE_MID;
          default: c.cmd = CMD_SPARE_HI;
        endcase
      end else begin
        // noise: a read or write anywhere, mostly out of range
        c.cmd = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE;
        c.field_width = 7'(w);
        return c;
      end
    end
    // keep reads and writes inside the string where the width allows
    if ((c.cmd == CMD_READ || c.cmd == CMD_WRITE) && w <= len) begin
      c.bit_position = 12'($urandom_range(0, len - w));
    end
    c.field_width = 7'(w);
    return c;
  endfunction

  // Offer one item after a random gap; predict its result once accepted
  task automatic issue_command(input cmd_t c, input bit typed, input res_t want);
    int gap;
    res_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_command(c);
    predicted_results.insert(predicted_results.size(), typed ? want : predicted);
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        $error("unexpected result item: read_value %h length_bits %0d status %0d",
               out_data.read_value, out_data.length_bits, out_data.status);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        if (out_data.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_data.read_value);
          mismatches++;
        end
        if (out_data.length_bits !== want.length_bits) begin
          $error("length_bits: expected %0d, got %0d", want.length_bits, out_data.length_bits);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off to back the block up
  initial begin : drain_results
    int stall;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (taken == HOLD_AFTER) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Stimulus
  initial begin : drive_commands
    plan_row_t row;
    for (int i = 0; i < DEPTH_WORDS; i++) model_words[i] = '0;

    // directed table, starting from the empty store
    add_row(plan_row(CMD_READ, 0, 0, '0, 1, 0, STATUS_DONE));
    add_row(plan_row(CMD_READ, 0, 1, '0, 1, 0, STATUS_REJECTED));
    add_row(plan_row(CMD_APPEND, 0, 0, '1, 1, 0, STATUS_DONE));
    add_row(plan_row(CMD_APPEND, 0, 64, '1, 1, 64, STATUS_DONE));
    add_row(plan_row(CMD_APPEND, 0, 65, '1, 1, 64, STATUS_REJECTED));
    add_row(plan_row(CMD_APPEND, 4095, 127, '1, 1, 64, STATUS_REJECTED));
    add_row(plan_row(CMD_APPEND, 0, 1, '0, 1, 65, STATUS_DONE));
    add_row(plan_row(CMD_APPEND, 0, 63, 64'hA5A5_5A5A_C3C3_3C3C, 1, 128, STATUS_DONE));
    // field straddling words 0 and 1
    add_row(plan_row(CMD_READ, 60, 64, '0, 0, 0, STATUS_DONE));
    add_row(plan_row(CMD_WRITE, 32, 64, 64'h0123_4567_89AB_CDEF, 0, 0, STATUS_DONE));
    add_row(plan_row(CMD_READ, 0, 64, '0, 0, 0, STATUS_DONE));
    add_row(plan_row(CMD_READ, 64, 64, '0, 0, 0, STATUS_DONE));
    // ranges past the length, then empty fields, drops and spare codes
    add_row(plan_row(CMD_READ, 65, 64, '0, 1, 128, STATUS_REJECTED));
    add_row(plan_row(CMD_WRITE, 100, 29, '1, 1, 128, STATUS_REJECTED));
    add_row(plan_row(CMD_WRITE, 4095, 1, '1, 1, 128, STATUS_REJECTED));
    add_row(plan_row(CMD_WRITE, 0, 0, '1, 1, 128, STATUS_DONE));
    add_row(plan_row(CMD_READ, 127, 1, '0, 0, 0, STATUS_DONE));
    add_row(plan_row(CMD_DROP, 0, 0, '0, 1, 128, STATUS_DONE));
    add_row(plan_row(CMD_DROP, 0, 3, '0, 1, 125, STATUS_DONE));
    add_row(plan_row(CMD_READ, 120, 5, '0, 0, 0, STATUS_DONE));
    add_row(plan_row(CMD_SPARE_LO, 0, 1, '1, 1, 125, STATUS_REJECTED));
    add_row(plan_row(CMD_SPARE_MID, 0, 1, '1, 1, 125, STATUS_REJECTED));
    add_row(plan_row(CMD_SPARE_HI, 0, 1, '1, 1, 125, STATUS_REJECTED));
    // drop of more than the length empties the string
    add_row(plan_row(CMD_DROP, 0, 127, '0, 1, 0, STATUS_DONE));
    add_row(plan_row(CMD_APPEND, 0, 64, 64'hDEAD_BEEF_0F0F_F0F0, 0, 0, STATUS_DONE));
    add_row(plan_row(CMD_CLEAR, 0, 0, '0, 1, 0, STATUS_DONE));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      issue_command(row.item, row.check_typed, row.want);
    end

    // let the directed results drain before the random part
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = ((i / 100) % 4 == 3);
      if (i == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge clk);
      end
      issue_command(draw_command((i / 125) % 3 == 1), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("packed_bit_field_store: match");
    end else begin
      $display("packed_bit_field_store: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("packed_bit_field_store: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
src/pbfs_pkg.sv
src/pbfs_queue.sv
src/pbfs_front.sv
src/pbfs_back.sv
src/packed_bit_field_store.sv
tb/sv/tb_packed_bit_field_store.sv
